// ----- rtl/tpcc_pkg.sv -----
// shared types, register indexes and colour constants for the point colour classifier
`default_nettype none
package tpcc_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAN_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_RECIPROCAL = 2'd2;

  localparam logic [15:0] LEVEL_THRESHOLD_RST = 16'd26214;
  localparam logic [23:0] TAN_LIMIT_RST = 24'd17560;
  localparam logic [31:0] SPAN_RECIPROCAL_RST = 32'd109227;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [23:0] RED_RGB = 24'hFF_0000;
  localparam logic [23:0] BLACK_RGB = 24'h00_0000;
  localparam logic [7:0] FULL = 8'd255;

  typedef enum logic [1:0] {
    CLASS_TILTED = 2'd0,
    CLASS_COLOURED = 2'd1,
    CLASS_LEVEL = 2'd2
  } class_t;

  // rainbow segment, named by the colour it starts from
  typedef enum logic [2:0] {
    SEG_GREEN = 3'd0,
    SEG_CYAN = 3'd1,
    SEG_BLUE = 3'd2,
    SEG_MAGENTA = 3'd3,
    SEG_RED = 3'd4,
    SEG_YELLOW = 3'd5,
    SEG_END = 3'd6
  } seg_t;

  typedef struct packed {
    logic [15:0] level_threshold;
    logic [23:0] tan_limit;
    logic [31:0] span_reciprocal;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } coord_t;

  typedef struct packed {
    coord_t      coord;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic [15:0] diff;
    logic        above;
  } abs_stage_t;

  typedef struct packed {
    coord_t      coord;
    logic [15:0] ax;
    logic [15:0] az;
    logic [39:0] lim;
    logic [47:0] prod;
    logic        above;
  } mul_stage_t;

  typedef struct packed {
    coord_t      coord;
    class_t      cls;
    seg_t        seg;
    logic [15:0] frac;
  } grade_stage_t;

  typedef struct packed {
    coord_t      coord;
    class_t      cls;
    logic [23:0] colour;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/tpcc_ifs.sv -----
// request channels: point input, classified result and register writes
`default_nettype none
interface tpcc_in_if import tpcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic [15:0]        unevenness;

  modport source (output valid, point_x, point_y, point_z, norm_x, norm_y, norm_z,
                  unevenness, input ready);
  modport sink (input valid, point_x, point_y, point_z, norm_x, norm_y, norm_z,
                unevenness, output ready);
endinterface

interface tpcc_out_if import tpcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [1:0]         point_class;
  logic [23:0]        colour_rgb;

  modport source (output valid, out_x, out_y, out_z, point_class, colour_rgb,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, point_class, colour_rgb,
                output ready);
endinterface

interface tpcc_cfg_if import tpcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/tpcc_cfg_regs.sv -----
// configuration register file with reset defaults
`default_nettype none
module tpcc_cfg_regs import tpcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign wr_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_valid) begin
      case (wr_index)
        REG_LEVEL_THRESHOLD: cfg_nxt.level_threshold = wr_data[15:0];
        REG_TAN_LIMIT:       cfg_nxt.tan_limit = wr_data[23:0];
        REG_SPAN_RECIPROCAL: cfg_nxt.span_reciprocal = wr_data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_threshold <= LEVEL_THRESHOLD_RST;
      cfg_r.tan_limit <= TAN_LIMIT_RST;
      cfg_r.span_reciprocal <= SPAN_RECIPROCAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- rtl/tpcc_front.sv -----
// first two stages: magnitudes and threshold difference, then the two products
`default_nettype none
module tpcc_front import tpcc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               up_valid,
  output logic               up_ready,
  input  coord_t             up_coord,
  input  logic signed [15:0] norm_x,
  input  logic signed [15:0] norm_y,
  input  logic signed [15:0] norm_z,
  input  logic [15:0]        unevenness,
  output logic               dn_valid,
  input  logic               dn_ready,
  output mul_stage_t         dn_data
);

  logic       a_valid_r;
  logic       a_valid_nxt;
  abs_stage_t a_data_r;
  abs_stage_t a_data_nxt;
  logic       a_adv;
  logic       b_valid_r;
  logic       b_valid_nxt;
  mul_stage_t b_data_r;
  mul_stage_t b_data_nxt;
  logic       b_adv;

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [15:0] u;
    u = v;
    // -1.0 maps to 0x8000, still exact as unsigned
    return v[15] ? (~u + 16'd1) : u;
  endfunction

  assign b_adv = !b_valid_r || dn_ready;
  assign a_adv = !a_valid_r || b_adv;
  assign up_ready = a_adv;

  always_comb begin
    a_valid_nxt = a_adv ? up_valid : a_valid_r;
    a_data_nxt.coord = up_coord;
    a_data_nxt.ax = mag16(norm_x);
    a_data_nxt.ay = mag16(norm_y);
    a_data_nxt.az = mag16(norm_z);
    a_data_nxt.diff = unevenness - cfg.level_threshold;
    a_data_nxt.above = unevenness > cfg.level_threshold;
  end

  always_comb begin
    b_valid_nxt = b_adv ? a_valid_r : b_valid_r;
    b_data_nxt.coord = a_data_r.coord;
    b_data_nxt.ax = a_data_r.ax;
    b_data_nxt.az = a_data_r.az;
    b_data_nxt.lim = 40'(cfg.tan_limit) * 40'(a_data_r.ay);
    b_data_nxt.prod = 48'(a_data_r.diff) * 48'(cfg.span_reciprocal);
    b_data_nxt.above = a_data_r.above;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      a_data_r <= a_data_nxt;
    end
    if (b_adv) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_data = b_data_r;

endmodule
`default_nettype wire

// ----- rtl/tpcc_grade.sv -----
// third stage: slope test, clamp and rainbow segment split
`default_nettype none
module tpcc_grade import tpcc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  mul_stage_t   up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output grade_stage_t dn_data
);

  logic         valid_r;
  logic         valid_nxt;
  grade_stage_t data_r;
  grade_stage_t data_nxt;
  logic         adv;
  logic         tilted;
  logic [31:0]  pos_full;
  logic [16:0]  pos;
  logic [18:0]  m;

  assign adv = !valid_r || dn_ready;
  assign up_ready = adv;

  always_comb begin
    tilted = ({8'd0, up_data.ax, 16'd0} > up_data.lim) ||
             ({8'd0, up_data.az, 16'd0} > up_data.lim);
    pos_full = up_data.prod[47:16];
    pos = (pos_full > ONE_Q16) ? ONE_Q16[16:0] : pos_full[16:0];
    // six times pos, at most 6.0 in Q3.16
    m = {pos, 2'b00} + {1'b0, pos, 1'b0};
    data_nxt.coord = up_data.coord;
    data_nxt.seg = seg_t'(m[18:16]);
    data_nxt.frac = m[15:0];
    if (tilted) begin
      data_nxt.cls = CLASS_TILTED;
    end else if (up_data.above) begin
      data_nxt.cls = CLASS_COLOURED;
    end else begin
      data_nxt.cls = CLASS_LEVEL;
    end
    valid_nxt = adv ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data = data_r;

endmodule
`default_nettype wire

// ----- rtl/tpcc_paint.sv -----
// last stage: ramp value and colour selection, doubles as the output register
`default_nettype none
module tpcc_paint import tpcc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  grade_stage_t up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output result_t      dn_data
);

  logic        valid_r;
  logic        valid_nxt;
  result_t     data_r;
  result_t     data_nxt;
  logic        adv;
  logic [23:0] ramp;
  logic [7:0]  t;
  logic [7:0]  r;
  logic [7:0]  g;
  logic [7:0]  b;

  assign adv = !valid_r || dn_ready;
  assign up_ready = adv;

  always_comb begin
    // frac * 255 as a shift and subtract
    ramp = {up_data.frac, 8'd0} - {8'd0, up_data.frac};
    t = ramp[23:16];
    case (up_data.seg)
      SEG_GREEN: begin
        r = 8'd0; g = FULL; b = t;
      end
      SEG_CYAN: begin
        r = 8'd0; g = FULL - t; b = FULL;
      end
      SEG_BLUE: begin
        r = t; g = 8'd0; b = FULL;
      end
      SEG_MAGENTA: begin
        r = FULL; g = 8'd0; b = FULL - t;
      end
      SEG_RED: begin
        r = FULL; g = t; b = 8'd0;
      end
      SEG_YELLOW: begin
        r = FULL - t; g = FULL; b = 8'd0;
      end
      default: begin
        r = 8'd0; g = FULL; b = 8'd0;
      end
    endcase
    data_nxt.coord = up_data.coord;
    data_nxt.cls = up_data.cls;
    case (up_data.cls)
      CLASS_TILTED:   data_nxt.colour = RED_RGB;
      CLASS_COLOURED: data_nxt.colour = {r, g, b};
      default:        data_nxt.colour = BLACK_RGB;
    endcase
    valid_nxt = adv ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data = data_r;

endmodule
`default_nettype wire

// ----- rtl/traversability_point_colour_classifier_unit.sv -----
// Point colour classifier: takes one point per cycle and returns its coordinates, a class
// and a packed RGB colour. Red marks a normal tilted past tan_limit from the y axis, a
// rainbow colour marks unevenness above level_threshold (scaled by span_reciprocal and
// clamped to 1.0), black marks everything else. Four register stages (magnitudes, the two
// multipliers, slope test and clamp, colour select), passed in that order; one point is taken
// every cycle while the result side keeps up. A stalled result side fills the stages first,
// so in ready drops only once all four hold a point. Register writes take effect at once and
// belong to idle periods.
`default_nettype none
module traversability_point_colour_classifier_unit import tpcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tpcc_in_if.sink   in_chan,
  tpcc_out_if.source out_chan,
  tpcc_cfg_if.sink  cfg_chan
);

  cfg_t         cfg;
  logic         mul_valid;
  logic         mul_ready;
  mul_stage_t   mul_data;
  logic         grade_valid;
  logic         grade_ready;
  grade_stage_t grade_data;
  result_t      result;
  coord_t       in_coord;

  assign in_coord.x = in_chan.point_x;
  assign in_coord.y = in_chan.point_y;
  assign in_coord.z = in_chan.point_z;

  tpcc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_chan.valid),
    .wr_ready (cfg_chan.ready),
    .wr_index (cfg_chan.index),
    .wr_data  (cfg_chan.data),
    .cfg      (cfg)
  );

  tpcc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .up_valid   (in_chan.valid),
    .up_ready   (in_chan.ready),
    .up_coord   (in_coord),
    .norm_x     (in_chan.norm_x),
    .norm_y     (in_chan.norm_y),
    .norm_z     (in_chan.norm_z),
    .unevenness (in_chan.unevenness),
    .dn_valid   (mul_valid),
    .dn_ready   (mul_ready),
    .dn_data    (mul_data)
  );

  tpcc_grade u_grade (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mul_valid),
    .up_ready (mul_ready),
    .up_data  (mul_data),
    .dn_valid (grade_valid),
    .dn_ready (grade_ready),
    .dn_data  (grade_data)
  );

  tpcc_paint u_paint (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (grade_valid),
    .up_ready (grade_ready),
    .up_data  (grade_data),
    .dn_valid (out_chan.valid),
    .dn_ready (out_chan.ready),
    .dn_data  (result)
  );

  assign out_chan.out_x = result.coord.x;
  assign out_chan.out_y = result.coord.y;
  assign out_chan.out_z = result.coord.z;
  assign out_chan.point_class = result.cls;
  assign out_chan.colour_rgb = result.colour;

`ifndef SYNTHESIS
  // a tilted point always leaves as red, a level one as black
  a_tilted_red: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.point_class == CLASS_TILTED) |->
      (out_chan.colour_rgb == RED_RGB))
    else $error("tilted point not red");

  a_level_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.point_class == CLASS_LEVEL) |->
      (out_chan.colour_rgb == BLACK_RGB))
    else $error("level point not black");

  // input is held off only while a result waits at the output
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_chan.valid && !out_chan.ready))
    else $error("input stalled without output stall");

  // a taken point reaches the output while the result side stays free
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready ##1 out_chan.ready [*3]) |=> out_chan.valid)
    else $error("result missing after pipeline latency");

  a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.point_class <= CLASS_LEVEL))
    else $error("unused class code on output");
`endif

endmodule
`default_nettype wire
